// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the efps_chk checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

`define ASSERT_DEF(lbl, prop) `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== hdl/efps_pkg.sv =====
package efps_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned MAX_HULL_DEF   = 16;
  localparam int unsigned SMALL_SET      = 4;
  localparam int unsigned NUM_EXT        = 6;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned LIMIT_W        = 5;
  localparam int unsigned LIMIT_RST      = 16;
  localparam int unsigned EMIT_W         = 7;
  // read register plus four distance stages
  localparam int unsigned DIST_LAT       = 5;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_PUT
  } state_e;

  typedef enum logic [1:0] {
    PH_SMALL,
    PH_EXT,
    PH_CHAIN
  } phase_e;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== hdl/efps_if.sv =====
interface efps_point_if;
  import efps_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  logic   last_point;
  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface efps_hull_if;
  import efps_pkg::*;
  logic   valid;
  logic   ready;
  coord_t hull_x;
  coord_t hull_y;
  coord_t hull_z;
  logic   last_hull;
  modport source (output valid, hull_x, hull_y, hull_z, last_hull, input ready);
  modport sink   (input valid, hull_x, hull_y, hull_z, last_hull, output ready);
endinterface

// ===== hdl/efps_cell.sv =====
module efps_cell #(
  parameter int unsigned DIST_W = 58,
  parameter int unsigned IDX_W  = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  efps_pkg::cell_ctl_t ctl_i,
  input  logic              in_vld_i,
  input  logic [DIST_W-1:0] in_dist_i,
  input  logic [IDX_W-1:0]  in_idx_i,
  input  logic              nxt_vld_i,
  input  logic [DIST_W-1:0] nxt_dist_i,
  input  logic [IDX_W-1:0]  nxt_idx_i,
  output logic              hold_vld_o,
  output logic [DIST_W-1:0] hold_dist_o,
  output logic [IDX_W-1:0]  hold_idx_o,
  output logic              pass_vld_o,
  output logic [DIST_W-1:0] pass_dist_o,
  output logic [IDX_W-1:0]  pass_idx_o
);
  import efps_pkg::*;

  logic              hold_vld_q, pass_vld_q;
  logic [DIST_W-1:0] hold_dist_q, pass_dist_q;
  logic [IDX_W-1:0]  hold_idx_q, pass_idx_q;
  logic              beats;

  // farther first, equal distance goes to the higher index
  assign beats = (in_dist_i > hold_dist_q) ||
                 ((in_dist_i == hold_dist_q) && (in_idx_i > hold_idx_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      pass_vld_q <= 1'b0;
    end else if (ctl_i.clear) begin
      hold_vld_q <= 1'b0;
      pass_vld_q <= 1'b0;
    end else if (ctl_i.shift) begin
      hold_vld_q <= nxt_vld_i;
      pass_vld_q <= 1'b0;
    end else if (in_vld_i) begin
      hold_vld_q <= 1'b1;
      pass_vld_q <= hold_vld_q;
    end else begin
      pass_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ctl_i.clear) begin
      if (ctl_i.shift) begin
        hold_dist_q <= nxt_dist_i;
        hold_idx_q  <= nxt_idx_i;
      end else if (in_vld_i) begin
        if (!hold_vld_q || beats) begin
          hold_dist_q <= in_dist_i;
          hold_idx_q  <= in_idx_i;
          pass_dist_q <= hold_dist_q;
          pass_idx_q  <= hold_idx_q;
        end else begin
          pass_dist_q <= in_dist_i;
          pass_idx_q  <= in_idx_i;
        end
      end
    end
  end

  assign hold_vld_o  = hold_vld_q;
  assign hold_dist_o = hold_dist_q;
  assign hold_idx_o  = hold_idx_q;
  assign pass_vld_o  = pass_vld_q;
  assign pass_dist_o = pass_dist_q;
  assign pass_idx_o  = pass_idx_q;

endmodule

// ===== hdl/efps_dist.sv =====
module efps_dist #(
  parameter int unsigned CW    = 11,
  parameter int unsigned SW    = 27,
  parameter int unsigned IDX_W = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  efps_pkg::coord_t      p_i [3],
  input  logic [CW-1:0]         n_i,
  input  logic signed [SW-1:0]  sum_i [3],
  output logic                  vld_o,
  output logic [IDX_W-1:0]      idx_o,
  output logic [2*SW+3:0]       dist_o
);
  import efps_pkg::*;

  localparam int unsigned DW = SW + 1;
  localparam int unsigned PW = CW + COORD_W + 1;
  localparam int unsigned QW = 2 * DW;

  logic                 vld1_q, vld2_q, vld3_q, vld4_q;
  logic [IDX_W-1:0]     idx1_q, idx2_q, idx3_q, idx4_q;
  logic [SW-1:0]        prod_q [3];
  logic signed [DW-1:0] d_q [3];
  logic [2*DW-1:0]      sq_q [3];
  logic [2*DW+1:0]      dist_q;
  logic signed [PW-1:0] prod_w [3];
  logic signed [QW-1:0] sq_w [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_w[a] = PW'($signed({1'b0, n_i})) * PW'(p_i[a]);
      sq_w[a]   = QW'(d_q[a]) * QW'(d_q[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= idx_i;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    idx4_q <= idx3_q;
    for (int a = 0; a < 3; a++) begin
      prod_q[a] <= prod_w[a][SW-1:0];
      d_q[a]    <= {prod_q[a][SW-1], prod_q[a]} - {sum_i[a][SW-1], sum_i[a]};
      sq_q[a]   <= sq_w[a];
    end
    dist_q <= {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
  end

  assign vld_o  = vld4_q;
  assign idx_o  = idx4_q;
  assign dist_o = dist_q;

endmodule

// ===== hdl/extreme_and_farthest_point_select_top.sv =====
// Loading takes one point per cycle; the block holds no input while a set is selected.
// Sets of up to four points are emitted in input order once the last point is in.
// Larger sets: one scan through the distance pipeline into the sorting cell row, a
// drain, then results from the point memory read port, each read before it is put
// out, and a stalled output holds the next read. Reset clears control and sets limit 16.
module extreme_and_farthest_point_select_top #(
  parameter int unsigned MAX_POINTS = efps_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_HULL   = efps_pkg::MAX_HULL_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [efps_pkg::LIMIT_W-1:0]  cfg_data_i,
  efps_point_if.sink                    point_i,
  efps_hull_if.source                   hull_o
);
  import efps_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_POINTS);
  localparam int unsigned CW      = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW      = COORD_W + CW;
  localparam int unsigned DSW     = 2 * SW + 4;
  localparam int unsigned DRAIN_N = DIST_LAT + MAX_HULL + 2;
  localparam int unsigned DRW     = $clog2(DRAIN_N + 1);

  state_e state_q, state_d;
  phase_e phase_q;

  logic [3*COORD_W-1:0] mem_q [MAX_POINTS];
  logic [3*COORD_W-1:0] rd_data_q;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;

  logic [LIMIT_W-1:0]   limit_q;
  logic [CW-1:0]        count_q, cnt_nxt;
  logic signed [SW-1:0] sum_q [3];
  coord_t               ext_val_q [NUM_EXT];
  logic [AW-1:0]        ext_idx_q [NUM_EXT];
  coord_t               in_p [3];
  coord_t               rd_p [3];

  logic [AW-1:0]        scan_q, last_idx, emit_idx_q, prev_q, sel;
  logic [DRW-1:0]       drain_q;
  logic                 have_prev_q, more, found, match;
  logic [EMIT_W-1:0]    n_emit_q, lim;
  logic                 lim_reached, last_q, put, in_acc;
  logic                 iss_vld_q;
  logic [AW-1:0]        iss_idx_q;

  logic                 out_vld_q, out_last_q;
  coord_t               out_x_q, out_y_q, out_z_q;

  cell_ctl_t            cell_ctl;
  logic                 c_vld  [MAX_HULL+1];
  logic [DSW-1:0]       c_dist [MAX_HULL+1];
  logic [AW-1:0]        c_idx  [MAX_HULL+1];
  logic                 h_vld  [MAX_HULL+1];
  logic [DSW-1:0]       h_dist [MAX_HULL+1];
  logic [AW-1:0]        h_idx  [MAX_HULL+1];

  assign in_p[0] = point_i.point_x;
  assign in_p[1] = point_i.point_y;
  assign in_p[2] = point_i.point_z;
  assign rd_p[0] = rd_data_q[COORD_W-1:0];
  assign rd_p[1] = rd_data_q[2*COORD_W-1:COORD_W];
  assign rd_p[2] = rd_data_q[3*COORD_W-1:2*COORD_W];

  assign point_i.ready = (state_q == ST_LOAD);
  assign in_acc   = point_i.valid && point_i.ready;
  assign cnt_nxt  = (count_q < CW'(MAX_POINTS)) ? count_q + CW'(1) : count_q;
  assign last_idx = AW'(count_q - CW'(1));
  assign lim      = (EMIT_W'(limit_q) > EMIT_W'(MAX_HULL)) ? EMIT_W'(MAX_HULL)
                                                           : EMIT_W'(limit_q);
  assign lim_reached = (n_emit_q + EMIT_W'(1)) >= lim;

  // next distinct extreme index in ascending order
  always_comb begin
    found = 1'b0;
    sel   = '0;
    more  = 1'b0;
    match = 1'b0;
    for (int e = 0; e < NUM_EXT; e++) begin
      if ((!have_prev_q || ext_idx_q[e] > prev_q) && (!found || ext_idx_q[e] < sel)) begin
        sel   = ext_idx_q[e];
        found = 1'b1;
      end
    end
    for (int e = 0; e < NUM_EXT; e++) begin
      if (ext_idx_q[e] > sel) begin
        more = 1'b1;
      end
      if (ext_idx_q[e] == scan_q) begin
        match = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    rd_en          = 1'b0;
    rd_addr        = scan_q;
    put            = 1'b0;
    cell_ctl.clear = (state_q == ST_LOAD);
    cell_ctl.shift = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && point_i.last_point) begin
          state_d = (cnt_nxt <= CW'(SMALL_SET)) ? ST_PICK : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_q == last_idx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_q == '0) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        rd_en   = 1'b1;
        state_d = ST_PUT;
        unique case (phase_q)
          PH_SMALL: rd_addr = emit_idx_q;
          PH_EXT:   rd_addr = sel;
          PH_CHAIN: begin
            rd_addr        = h_idx[0];
            cell_ctl.shift = 1'b1;
          end
          default:  rd_addr = emit_idx_q;
        endcase
      end
      ST_PUT: begin
        if (!out_vld_q || hull_o.ready) begin
          put     = 1'b1;
          state_d = last_q ? ST_LOAD : ST_PICK;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (count_q < CW'(MAX_POINTS))) begin
      mem_q[count_q[AW-1:0]] <= {point_i.point_z, point_i.point_y, point_i.point_x};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_W'(LIMIT_RST);
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= '0;
      end
      phase_q     <= PH_SMALL;
      scan_q      <= '0;
      drain_q     <= '0;
      emit_idx_q  <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      n_emit_q    <= '0;
      last_q      <= 1'b0;
      iss_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      iss_vld_q <= (state_q == ST_SCAN) && !match;
      if (in_acc) begin
        count_q <= cnt_nxt;
        if (count_q < CW'(MAX_POINTS)) begin
          for (int a = 0; a < 3; a++) begin
            sum_q[a] <= sum_q[a] + {{(SW-COORD_W){in_p[a][COORD_W-1]}}, in_p[a]};
          end
        end
        if (point_i.last_point) begin
          phase_q <= (cnt_nxt <= CW'(SMALL_SET)) ? PH_SMALL : PH_EXT;
          scan_q  <= '0;
        end
      end
      if (state_q == ST_SCAN) begin
        scan_q  <= scan_q + AW'(1);
        drain_q <= DRW'(DRAIN_N);
      end
      if (state_q == ST_DRAIN) begin
        drain_q <= drain_q - DRW'(1);
      end
      if (state_q == ST_PICK) begin
        n_emit_q <= n_emit_q + EMIT_W'(1);
        unique case (phase_q)
          PH_SMALL: begin
            last_q     <= (emit_idx_q == last_idx);
            emit_idx_q <= emit_idx_q + AW'(1);
          end
          PH_EXT: begin
            prev_q      <= sel;
            have_prev_q <= 1'b1;
            last_q      <= !more && (lim_reached || !h_vld[0]);
            if (!more) begin
              phase_q <= PH_CHAIN;
            end
          end
          PH_CHAIN: last_q <= lim_reached || !h_vld[1];
          default:  last_q <= 1'b1;
        endcase
      end
      if (put) begin
        out_vld_q <= 1'b1;
        if (last_q) begin
          count_q     <= '0;
          for (int a = 0; a < 3; a++) begin
            sum_q[a] <= '0;
          end
          n_emit_q    <= '0;
          have_prev_q <= 1'b0;
          emit_idx_q  <= '0;
        end
      end else if (hull_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iss_idx_q <= scan_q;
    if (put) begin
      out_x_q    <= rd_p[0];
      out_y_q    <= rd_p[1];
      out_z_q    <= rd_p[2];
      out_last_q <= last_q;
    end
    if (in_acc && (count_q < CW'(MAX_POINTS))) begin
      for (int a = 0; a < 3; a++) begin
        if (count_q == '0) begin
          ext_val_q[2*a]   <= in_p[a];
          ext_val_q[2*a+1] <= in_p[a];
          ext_idx_q[2*a]   <= '0;
          ext_idx_q[2*a+1] <= '0;
        end else begin
          if (in_p[a] < ext_val_q[2*a]) begin
            ext_val_q[2*a] <= in_p[a];
            ext_idx_q[2*a] <= count_q[AW-1:0];
          end
          if (in_p[a] > ext_val_q[2*a+1]) begin
            ext_val_q[2*a+1] <= in_p[a];
            ext_idx_q[2*a+1] <= count_q[AW-1:0];
          end
        end
      end
    end
  end

  efps_dist #(
    .CW    (CW),
    .SW    (SW),
    .IDX_W (AW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (iss_vld_q),
    .idx_i  (iss_idx_q),
    .p_i    (rd_p),
    .n_i    (count_q),
    .sum_i  (sum_q),
    .vld_o  (c_vld[0]),
    .idx_o  (c_idx[0]),
    .dist_o (c_dist[0])
  );

  assign h_vld[MAX_HULL]  = 1'b0;
  assign h_dist[MAX_HULL] = '0;
  assign h_idx[MAX_HULL]  = '0;

  for (genvar k = 0; k < MAX_HULL; k++) begin : g_cell
    efps_cell #(
      .DIST_W (DSW),
      .IDX_W  (AW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl),
      .in_vld_i    (c_vld[k]),
      .in_dist_i   (c_dist[k]),
      .in_idx_i    (c_idx[k]),
      .nxt_vld_i   (h_vld[k+1]),
      .nxt_dist_i  (h_dist[k+1]),
      .nxt_idx_i   (h_idx[k+1]),
      .hold_vld_o  (h_vld[k]),
      .hold_dist_o (h_dist[k]),
      .hold_idx_o  (h_idx[k]),
      .pass_vld_o  (c_vld[k+1]),
      .pass_dist_o (c_dist[k+1]),
      .pass_idx_o  (c_idx[k+1])
    );
  end

  assign hull_o.valid     = out_vld_q;
  assign hull_o.hull_x    = out_x_q;
  assign hull_o.hull_y    = out_y_q;
  assign hull_o.hull_z    = out_z_q;
  assign hull_o.last_hull = out_last_q;

endmodule

// ===== hdl/efps_chk.sv =====
`include "assert_macros.svh"

module efps_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             in_last_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input efps_pkg::coord_t out_x_i,
  input efps_pkg::coord_t out_y_i,
  input efps_pkg::coord_t out_z_i,
  input logic             out_last_i
);
  import efps_pkg::*;

  `ASSERT_DEF(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `ASSERT_DEF(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_x_i) && $stable(out_y_i) && $stable(out_z_i) && $stable(out_last_i))
  `ASSERT_DEF(a_close_stops, in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
  `ASSERT_DEF(a_load_goes_on, in_valid_i && in_ready_i && !in_last_i |=> in_ready_i)

endmodule

bind extreme_and_farthest_point_select_top efps_chk u_efps_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (point_i.valid),
  .in_ready_i  (point_i.ready),
  .in_last_i   (point_i.last_point),
  .out_valid_i (hull_o.valid),
  .out_ready_i (hull_o.ready),
  .out_x_i     (hull_o.hull_x),
  .out_y_i     (hull_o.hull_y),
  .out_z_i     (hull_o.hull_z),
  .out_last_i  (hull_o.last_hull)
);

// ===== tb/efps_checker.sv =====
module efps_checker
  import efps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_data_i,
  efps_point_if              pt,
  efps_hull_if               hl,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } hull_item_t;

  hull_item_t hull_q[$];

  coord_t          px[MAX_POINTS_DEF];
  coord_t          py[MAX_POINTS_DEF];
  coord_t          pz[MAX_POINTS_DEF];
  logic            chosen[MAX_POINTS_DEF];
  int unsigned     npts;
  longint          sx, sy, sz;
  int unsigned     ext[NUM_EXT];
  logic [LIMIT_W-1:0] limit_r;

  assign pending = hull_q.size();

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void clear_set();
    npts = 0;
    sx = 0; sy = 0; sz = 0;
    foreach (ext[e]) ext[e] = 0;
    foreach (chosen[i]) chosen[i] = 1'b0;
  endfunction

  function automatic void add_point(coord_t x, coord_t y, coord_t z);
    int unsigned idx;
    if (npts < MAX_POINTS_DEF) begin
      idx = npts;
      px[idx] = x; py[idx] = y; pz[idx] = z;
      sx += x; sy += y; sz += z;
      if (idx != 0) begin
        if (x < px[ext[0]]) ext[0] = idx;
        if (x > px[ext[1]]) ext[1] = idx;
        if (y < py[ext[2]]) ext[2] = idx;
        if (y > py[ext[3]]) ext[3] = idx;
        if (z < pz[ext[4]]) ext[4] = idx;
        if (z > pz[ext[5]]) ext[5] = idx;
      end
      npts = idx + 1;
    end
  endfunction

  function automatic longint unsigned spread(int unsigned i);
    longint dx, dy, dz;
    dx = longint'(npts) * longint'(px[i]) - sx;
    dy = longint'(npts) * longint'(py[i]) - sy;
    dz = longint'(npts) * longint'(pz[i]) - sz;
    return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
  endfunction

  function automatic void push_point(int unsigned i);
    hull_item_t it;
    it.x = px[i]; it.y = py[i]; it.z = pz[i]; it.last = 1'b0;
    hull_q = {hull_q, it};
  endfunction

  function automatic void close_set();
    int unsigned n, lim, best;
    bit found;
    longint unsigned best_d, d;
    n = 0;
    if (npts <= SMALL_SET) begin
      for (int unsigned i = 0; i < npts; i++) begin
        push_point(i);
        n++;
      end
    end else begin
      lim = (limit_r > MAX_HULL_DEF) ? MAX_HULL_DEF : int'(limit_r);
      foreach (ext[e]) chosen[ext[e]] = 1'b1;
      for (int unsigned i = 0; i < npts; i++) begin
        if (chosen[i]) begin
          push_point(i);
          n++;
        end
      end
      while (n < lim) begin
        found = 0; best = 0; best_d = 0;
        for (int unsigned i = 0; i < npts; i++) begin
          if (!chosen[i]) begin
            d = spread(i);
            if (!found || d >= best_d) begin
              found = 1; best = i; best_d = d;
            end
          end
        end
        if (!found) break;
        chosen[best] = 1'b1;
        push_point(best);
        n++;
      end
    end
    if (n > 0) hull_q[hull_q.size()-1].last = 1'b1;
    clear_set();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hull_item_t exp_it;
    if (!rst_ni) begin
      hull_q.delete();
      clear_set();
      limit_r = LIMIT_W'(LIMIT_RST);
      fail_count = 0;
    end else begin
      if (cfg_we_i) limit_r = cfg_data_i;
      if (hl.valid && hl.ready) begin
        if (hull_q.size() == 0) begin
          report($sformatf("unexpected item (%0d,%0d,%0d)", hl.hull_x, hl.hull_y, hl.hull_z));
        end else begin
          exp_it = hull_q.pop_front();
          if (hl.hull_x !== exp_it.x)
            report($sformatf("hull_x %0d, want %0d", hl.hull_x, exp_it.x));
          if (hl.hull_y !== exp_it.y)
            report($sformatf("hull_y %0d, want %0d", hl.hull_y, exp_it.y));
          if (hl.hull_z !== exp_it.z)
            report($sformatf("hull_z %0d, want %0d", hl.hull_z, exp_it.z));
          if (hl.last_hull !== exp_it.last)
            report($sformatf("last_hull %0b, want %0b", hl.last_hull, exp_it.last));
        end
      end
      if (pt.valid && pt.ready) begin
        add_point(pt.point_x, pt.point_y, pt.point_z);
        if (pt.last_point) close_set();
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import efps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [LIMIT_W-1:0] cfg_data_i;
  int                 fail_count;
  int                 pending;
  int                 burst_left;
  int                 sent;
  int                 rx_mode;

  efps_point_if pt_if();
  efps_hull_if  hl_if();

  extreme_and_farthest_point_select_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .point_i    (pt_if),
    .hull_o     (hl_if)
  );

  efps_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .pt         (pt_if),
    .hl         (hl_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver stall pattern
  initial begin
    hl_if.ready = 1'b0;
    rx_mode = 0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: hl_if.ready = 1'b1;
        1: hl_if.ready = 1'($urandom_range(0, 1));
        2: hl_if.ready = ($urandom_range(0, 7) == 0);
        default: hl_if.ready = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_point(coord_t x, coord_t y, coord_t z, logic last);
    if (burst_left == 0) begin
      pt_if.valid = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    pt_if.valid = 1'b1;
    pt_if.point_x = x;
    pt_if.point_y = y;
    pt_if.point_z = z;
    pt_if.last_point = last;
    do @(posedge clk_i); while (!pt_if.ready);
    @(negedge clk_i);
    burst_left--;
    sent++;
  endtask

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom_range(0, 65535));
      1: return coord_t'($urandom_range(0, 6)) - 16'sd3;
      default: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  task automatic send_set(int n, int mode);
    for (int i = 0; i < n; i++)
      send_point(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), i == n - 1);
  endtask

  // write only once every queued item has drained
  task automatic set_limit(logic [LIMIT_W-1:0] v);
    pt_if.valid = 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    int mode;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.point_z = '0;
    pt_if.last_point = 1'b0;
    burst_left = 0;
    sent = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_point(16'sh7fff, 16'sh8000, 16'sh0000, 1'b1);
    send_point(16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh0001, 16'shffff, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    send_set(5, 2);
    for (int i = 0; i < 6; i++) send_point(16'sd5, -16'sd5, 16'sd0, i == 5);
    send_set(8, 1);
    set_limit(5'd6);
    send_set(10, 0);
    set_limit(5'd0);
    send_set(7, 0);
    set_limit(5'd31);
    send_set(20, 1);

    while (sent < 140) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: set_limit(5'd6);
          1: set_limit(5'd16);
          default: set_limit(5'($urandom_range(0, 31)));
        endcase
      end
      mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
      if ($urandom_range(0, 9) < 8) send_set($urandom_range(1, 12), mode);
      else send_set($urandom_range(13, 40), mode);
    end

    pt_if.valid = 1'b0;
    wait (pending == 0);
    repeat (60) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
